// ----- sv/qam_hard_decision_demapper_core_macros.svh -----
`ifndef QAM_HARD_DECISION_DEMAPPER_CORE_MACROS_SVH
`define QAM_HARD_DECISION_DEMAPPER_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define QHD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qam demapper check failed");

// next-cycle implication, checked outside reset
`define QHD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qam demapper check failed");

`endif

// ----- sv/qam_hdd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package qam_hdd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SYM_W      = 6;
  localparam int CNT_W      = 3;
  localparam int AXIS_MAX_W = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int ORDER_W    = 2;

  localparam logic REG_QAM_ORDER = 1'b0;

  typedef enum logic [ORDER_W-1:0] {
    MODE_QPSK  = 2'd0,
    MODE_QAM16 = 2'd1,
    MODE_QAM64 = 2'd2
  } qam_mode_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic so;
  } stage_en_t;

endpackage
`default_nettype wire

// ----- sv/qam_hdd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface qam_hdd_in_if;
  logic                                          valid;
  logic                                          ready;
  logic signed [qam_hdd_pkg::SAMPLE_W-1:0]       sample_re;
  logic signed [qam_hdd_pkg::SAMPLE_W-1:0]       sample_im;

  modport source (output valid, output sample_re, output sample_im, input ready);
  modport sink   (input valid, input sample_re, input sample_im, output ready);
endinterface

interface qam_hdd_out_if;
  logic                                valid;
  logic                                ready;
  logic [qam_hdd_pkg::SYM_W-1:0]       symbol_bits;
  logic [qam_hdd_pkg::CNT_W-1:0]       bit_count;

  modport source (output valid, output symbol_bits, output bit_count, input ready);
  modport sink   (input valid, input symbol_bits, input bit_count, output ready);
endinterface
`default_nettype wire

// ----- sv/qam_hdd_axis.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qam_hdd_axis #(
  parameter int FRAC_BITS = 8,
  parameter int AXIS_W    = 3
) (
  input  wire                                           clk,
  input  qam_hdd_pkg::stage_en_t                        en,
  input  wire logic signed [qam_hdd_pkg::SAMPLE_W-1:0]  x_s1,
  input  qam_hdd_pkg::qam_mode_t                        mode_s1,
  input  qam_hdd_pkg::qam_mode_t                        mode_s2,
  output logic [AXIS_W-1:0]                             idx_s3
);

  localparam int OFS_W = AXIS_W + 1 + FRAC_BITS;
  localparam int SUM_W = ((OFS_W > qam_hdd_pkg::SAMPLE_W - 1) ? OFS_W
                         : qam_hdd_pkg::SAMPLE_W - 1) + 2;
  localparam int Q_W   = SUM_W - FRAC_BITS - 1;

  localparam logic signed [SUM_W-1:0] BIAS_QPSK  = SUM_W'((1 << (FRAC_BITS + 1)) - 1);
  localparam logic signed [SUM_W-1:0] BIAS_QAM16 = SUM_W'((1 << (FRAC_BITS + 2)) - 1);
  localparam logic signed [SUM_W-1:0] BIAS_QAM64 = SUM_W'((1 << (FRAC_BITS + 3)) - 1);

  logic signed [SUM_W-1:0]      bias;
  logic signed [SUM_W-1:0]      sum_nxt;
  logic signed [SUM_W-1:0]      sum_r;
  logic [Q_W-1:0]               q;
  logic [qam_hdd_pkg::AXIS_MAX_W-1:0] lim;
  logic [AXIS_W-1:0]            idx_nxt;
  logic [AXIS_W-1:0]            idx_r;

  // shift the grid so the lowest point sits at zero, rounding ties down
  always_comb begin
    case (mode_s1)
      qam_hdd_pkg::MODE_QPSK:  bias = BIAS_QPSK;
      qam_hdd_pkg::MODE_QAM16: bias = BIAS_QAM16;
      default:                 bias = BIAS_QAM64;
    endcase
    sum_nxt = SUM_W'(x_s1) + bias;
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      sum_r <= sum_nxt;
    end
  end

  // divide by the point spacing and clamp to the grid edge
  always_comb begin
    case (mode_s2)
      qam_hdd_pkg::MODE_QPSK:  lim = qam_hdd_pkg::AXIS_MAX_W'(1);
      qam_hdd_pkg::MODE_QAM16: lim = qam_hdd_pkg::AXIS_MAX_W'(3);
      default:                 lim = qam_hdd_pkg::AXIS_MAX_W'(7);
    endcase
    q = sum_r[SUM_W-1:FRAC_BITS+1];
    if (sum_r[SUM_W-1]) begin
      idx_nxt = '0;
    end else if (q > Q_W'(lim)) begin
      idx_nxt = AXIS_W'(lim);
    end else begin
      idx_nxt = AXIS_W'(q);
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      idx_r <= idx_nxt;
    end
  end

  assign idx_s3 = idx_r;

endmodule
`default_nettype wire

// ----- sv/qam_hard_decision_demapper_core.sv -----
// Hard-decision demapper for square QPSK, 16-QAM and 64-QAM on natural binary labels. Each
// received sample (signed, FRAC_BITS fraction bits) is sliced on each axis independently to the
// nearest odd grid point, ties going to the lower index, and the two axis indices form the
// symbol label (in-phase index in the high half). One item is accepted every clock while the
// output is not stalled; each result passes through an input stage, a bias-add stage and a clamp
// stage in each axis slicer, then the output register. Back-pressure stalls the pipeline
// stage by stage, so bubbles are squeezed out and nothing is dropped. qam_order (byte address
// 0, reset 16-QAM) must only be written while no item is in flight; code 3 acts as 64-QAM, and
// orders above MAX_POINTS are lowered to the largest one allowed.
`timescale 1ns / 1ps
`default_nettype none
`include "qam_hard_decision_demapper_core_macros.svh"
module qam_hard_decision_demapper_core #(
  parameter int MAX_POINTS = 64,
  parameter int FRAC_BITS  = 8
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  qam_hdd_in_if.sink                                 in_ch,
  qam_hdd_out_if.source                              out_ch,
  input  wire                                        cfg_psel,
  input  wire                                        cfg_penable,
  input  wire                                        cfg_pwrite,
  input  wire [qam_hdd_pkg::CFG_ADDR_W-1:0]          cfg_paddr,
  input  wire [qam_hdd_pkg::CFG_DATA_W-1:0]          cfg_pwdata,
  output logic [qam_hdd_pkg::CFG_DATA_W-1:0]         cfg_prdata,
  output logic                                       cfg_pready
);

  localparam qam_hdd_pkg::qam_mode_t MAX_MODE =
    (MAX_POINTS >= 64) ? qam_hdd_pkg::MODE_QAM64 :
    (MAX_POINTS >= 16) ? qam_hdd_pkg::MODE_QAM16 : qam_hdd_pkg::MODE_QPSK;
  localparam int AXIS_W = int'(MAX_MODE) + 1;

  logic [qam_hdd_pkg::ORDER_W-1:0] order_r;
  logic [qam_hdd_pkg::ORDER_W-1:0] order_nxt;
  logic                            cfg_wr;

  qam_hdd_pkg::qam_mode_t mode_sat;
  qam_hdd_pkg::qam_mode_t mode_eff;
  qam_hdd_pkg::stage_en_t en;

  logic v1_r, v2_r, v3_r, vo_r;
  logic v1_nxt, v2_nxt, v3_nxt, vo_nxt;

  logic signed [qam_hdd_pkg::SAMPLE_W-1:0] re_s1_r;
  logic signed [qam_hdd_pkg::SAMPLE_W-1:0] im_s1_r;
  qam_hdd_pkg::qam_mode_t mode_s1_r;
  qam_hdd_pkg::qam_mode_t mode_s2_r;
  qam_hdd_pkg::qam_mode_t mode_s3_r;

  logic [AXIS_W-1:0]                  idx_i;
  logic [AXIS_W-1:0]                  idx_j;
  logic [qam_hdd_pkg::AXIS_MAX_W-1:0] ix;
  logic [qam_hdd_pkg::AXIS_MAX_W-1:0] jx;

  logic [qam_hdd_pkg::SYM_W-1:0] sym_nxt;
  logic [qam_hdd_pkg::SYM_W-1:0] sym_r;
  logic [qam_hdd_pkg::CNT_W-1:0] cnt_nxt;
  logic [qam_hdd_pkg::CNT_W-1:0] cnt_r;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  (cfg_paddr[qam_hdd_pkg::CFG_ADDR_W-1:2] == qam_hdd_pkg::REG_QAM_ORDER);

  always_comb begin
    order_nxt = order_r;
    if (cfg_wr) begin
      order_nxt = cfg_pwdata[qam_hdd_pkg::ORDER_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= qam_hdd_pkg::ORDER_W'(qam_hdd_pkg::MODE_QAM16);
    end else begin
      order_r <= order_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[qam_hdd_pkg::CFG_ADDR_W-1:2] == qam_hdd_pkg::REG_QAM_ORDER) begin
      cfg_prdata = qam_hdd_pkg::CFG_DATA_W'(order_r);
    end
  end

  // effective mode: reserved code saturates, then cap by MAX_POINTS
  always_comb begin
    case (order_r)
      qam_hdd_pkg::MODE_QPSK:  mode_sat = qam_hdd_pkg::MODE_QPSK;
      qam_hdd_pkg::MODE_QAM16: mode_sat = qam_hdd_pkg::MODE_QAM16;
      default:                 mode_sat = qam_hdd_pkg::MODE_QAM64;
    endcase
    mode_eff = (mode_sat > MAX_MODE) ? MAX_MODE : mode_sat;
  end

  // per-stage enables, a stage moves when its successor is empty or moving
  always_comb begin
    en.so = !vo_r || out_ch.ready;
    en.s3 = !v3_r || en.so;
    en.s2 = !v2_r || en.s3;
    en.s1 = !v1_r || en.s2;
  end

  assign in_ch.ready = en.s1;

  always_comb begin
    v1_nxt = en.s1 ? in_ch.valid : v1_r;
    v2_nxt = en.s2 ? v1_r : v2_r;
    v3_nxt = en.s3 ? v2_r : v3_r;
    vo_nxt = en.so ? v3_r : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      re_s1_r   <= in_ch.sample_re;
      im_s1_r   <= in_ch.sample_im;
      mode_s1_r <= mode_eff;
    end
    if (en.s2) begin
      mode_s2_r <= mode_s1_r;
    end
    if (en.s3) begin
      mode_s3_r <= mode_s2_r;
    end
  end

  qam_hdd_axis #(
    .FRAC_BITS (FRAC_BITS),
    .AXIS_W    (AXIS_W)
  ) u_axis_re (
    .clk     (clk),
    .en      (en),
    .x_s1    (re_s1_r),
    .mode_s1 (mode_s1_r),
    .mode_s2 (mode_s2_r),
    .idx_s3  (idx_i)
  );

  qam_hdd_axis #(
    .FRAC_BITS (FRAC_BITS),
    .AXIS_W    (AXIS_W)
  ) u_axis_im (
    .clk     (clk),
    .en      (en),
    .x_s1    (im_s1_r),
    .mode_s1 (mode_s1_r),
    .mode_s2 (mode_s2_r),
    .idx_s3  (idx_j)
  );

  // label = i * dim + j
  always_comb begin
    ix = qam_hdd_pkg::AXIS_MAX_W'(idx_i);
    jx = qam_hdd_pkg::AXIS_MAX_W'(idx_j);
    case (mode_s3_r)
      qam_hdd_pkg::MODE_QPSK: begin
        sym_nxt = {4'b0000, ix[0], jx[0]};
        cnt_nxt = qam_hdd_pkg::CNT_W'(2);
      end
      qam_hdd_pkg::MODE_QAM16: begin
        sym_nxt = {2'b00, ix[1:0], jx[1:0]};
        cnt_nxt = qam_hdd_pkg::CNT_W'(4);
      end
      default: begin
        sym_nxt = {ix, jx};
        cnt_nxt = qam_hdd_pkg::CNT_W'(6);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.so) begin
      sym_r <= sym_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_ch.valid       = vo_r;
  assign out_ch.symbol_bits = sym_r;
  assign out_ch.bit_count   = cnt_r;

  `QHD_ASSERT_NEXT(a_accept_fills_s1, in_ch.valid && in_ch.ready, v1_r)
  `QHD_ASSERT_NEXT(a_stall_keeps_s3, v3_r && !en.s3, v3_r && $stable(mode_s3_r))
  `QHD_ASSERT_NOW(a_count_legal, out_ch.valid,
    out_ch.bit_count == 3'd2 || out_ch.bit_count == 3'd4 || out_ch.bit_count == 3'd6)
  `QHD_ASSERT_NOW(a_qpsk_high_zero, out_ch.valid && out_ch.bit_count == 3'd2,
    out_ch.symbol_bits[5:2] == 4'b0000)

endmodule
`default_nettype wire
